FILE: rtl/core/mkd_pkg.sv
// shared types, constants and the letter lookup for the morse key decoder
`default_nettype none

package mkd_pkg;

  localparam int TIME_BITS   = 32;
  localparam int MAX_SYMBOLS = 15;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int REG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [REG_W-1:0]     reg_val_t;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_REMOTE_DOWN = 2'd1,
    OP_REMOTE_UP   = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LINK_FREE = 2'd0,
    LINK_TX   = 2'd1,
    LINK_RX   = 2'd2
  } link_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_LIMIT    = 3'd0,
    REG_DASH_LIMIT   = 3'd1,
    REG_MODE_HOLD    = 3'd2,
    REG_LETTER_GAP   = 3'd3,
    REG_IDLE_TIMEOUT = 3'd4
  } reg_idx_t;

  localparam logic       CHAN_TX = 1'b0;
  localparam logic       CHAN_RX = 1'b1;
  localparam logic [6:0] CH_DOT  = 7'h2E;
  localparam logic [6:0] CH_DASH = 7'h2D;

  typedef struct packed {
    reg_val_t dot_limit;
    reg_val_t dash_limit;
    reg_val_t mode_hold_ticks;
    reg_val_t letter_gap_ticks;
    reg_val_t idle_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       local_key;
  } item_t;

  typedef struct packed {
    logic       buzzer;
    logic [1:0] link_state;
    logic       mode;
    logic       mode_changed;
    logic       send_down;
    logic       send_up;
    logic       emit_valid;
    logic       emit_channel;
    logic [6:0] emit_char;
    logic       unknown_letter;
  } result_t;

  // letters by dash pattern, bit i set when symbol i is a dash
  localparam logic [6:0] LET1 [2]  = '{7'd69, 7'd84};
  localparam logic [6:0] LET2 [4]  = '{7'd73, 7'd78, 7'd65, 7'd77};
  localparam logic [6:0] LET3 [8]  = '{7'd83, 7'd68, 7'd82, 7'd71,
                                       7'd85, 7'd75, 7'd87, 7'd79};
  localparam logic [6:0] LET4 [16] = '{7'd72, 7'd66, 7'd76, 7'd90,
                                       7'd70, 7'd67, 7'd80, 7'd0,
                                       7'd86, 7'd88, 7'd0,  7'd81,
                                       7'd0,  7'd89, 7'd74, 7'd0};

  // zero means no letter for this count and pattern
  function automatic logic [6:0] mkd_letter(input logic [SYM_CNT_W-1:0] cnt,
                                            input logic [3:0] pat);
    logic [6:0] c;
    c = '0;
    unique case (cnt)
      SYM_CNT_W'(1): c = LET1[pat[0]];
      SYM_CNT_W'(2): c = LET2[pat[1:0]];
      SYM_CNT_W'(3): c = LET3[pat[2:0]];
      SYM_CNT_W'(4): c = LET4[pat];
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mkd_chan_if.sv
// valid/ready channel interfaces for key items and decoder results
`default_nettype none

interface mkd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       local_key;

  modport source (output valid, output op, output local_key, input ready);
  modport sink   (input valid, input op, input local_key, output ready);
endinterface

interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer;
  logic [1:0] link_state;
  logic       mode;
  logic       mode_changed;
  logic       send_down;
  logic       send_up;
  logic       emit_valid;
  logic       emit_channel;
  logic [6:0] emit_char;
  logic       unknown_letter;

  modport source (output valid, output buzzer, output link_state, output mode,
                  output mode_changed, output send_down, output send_up,
                  output emit_valid, output emit_channel, output emit_char,
                  output unknown_letter, input ready);
  modport sink   (input valid, input buzzer, input link_state, input mode,
                  input mode_changed, input send_down, input send_up,
                  input emit_valid, input emit_channel, input emit_char,
                  input unknown_letter, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mkd_cfg_regs.sv
// timing threshold registers with their reset values
`default_nettype none

module mkd_cfg_regs
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  reg_val_t             cfg_data,
  output cfg_t                 cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DOT_LIMIT:    cfg_nxt.dot_limit          = cfg_data;
        REG_DASH_LIMIT:   cfg_nxt.dash_limit         = cfg_data;
        REG_MODE_HOLD:    cfg_nxt.mode_hold_ticks    = cfg_data;
        REG_LETTER_GAP:   cfg_nxt.letter_gap_ticks   = cfg_data;
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout_ticks = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_limit          <= REG_W'(200);
      cfg_r.dash_limit         <= REG_W'(600);
      cfg_r.mode_hold_ticks    <= REG_W'(2000);
      cfg_r.letter_gap_ticks   <= REG_W'(800);
      cfg_r.idle_timeout_ticks <= REG_W'(3000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/mkd_in_stage.sv
// input register for key and remote event transactions
`default_nettype none

module mkd_in_stage
  import mkd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  mkd_in_if.sink in_chan,
  input  logic   take_i,
  output logic   item_valid_o,
  output item_t  item_o
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_chan.ready = !valid_r || take_i;
  assign load          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op        <= in_chan.op;
      item_r.local_key <= in_chan.local_key;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

`default_nettype wire

FILE: rtl/core/mkd_step.sv
// key timing state and the per-transaction decode step
`default_nettype none

module mkd_step
  import mkd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  time_t                tick_now_r, tick_now_nxt;
  time_t                tick_next_r, tick_next_nxt;
  time_t                press_begin_r, press_begin_nxt;
  time_t                release_time_r, release_time_nxt;
  time_t                far_press_begin_r, far_press_begin_nxt;
  time_t                activity_time_r, activity_time_nxt;
  logic                 key_down_r, key_down_nxt;
  logic                 far_key_down_r, far_key_down_nxt;
  logic                 switching_r, switching_nxt;
  logic                 mode_r, mode_nxt;
  logic                 buzzer_r, buzzer_nxt;
  link_t                link_r, link_nxt;
  logic [SYM_CNT_W-1:0] sym_count_r, sym_count_nxt;
  logic [3:0]           sym_pattern_r, sym_pattern_nxt;

  // elapsed times; local ones use the advanced tick
  time_t press_dur;
  time_t gap_dur;
  time_t idle_dur;
  time_t far_dur;
  time_t dot_lim, dash_lim, hold_lim, gap_lim, idle_lim;

  logic       finish;
  logic       push;
  logic       push_dash;
  logic [6:0] letter;
  result_t    res;

  assign dot_lim  = TIME_BITS'(cfg_i.dot_limit);
  assign dash_lim = TIME_BITS'(cfg_i.dash_limit);
  assign hold_lim = TIME_BITS'(cfg_i.mode_hold_ticks);
  assign gap_lim  = TIME_BITS'(cfg_i.letter_gap_ticks);
  assign idle_lim = TIME_BITS'(cfg_i.idle_timeout_ticks);

  assign press_dur = tick_next_r - press_begin_r;
  assign gap_dur   = tick_next_r - release_time_r;
  assign idle_dur  = tick_next_r - activity_time_r;
  assign far_dur   = tick_now_r - far_press_begin_r;

  assign letter = mkd_letter(sym_count_r, sym_pattern_r);

  always_comb begin
    tick_now_nxt        = tick_now_r;
    tick_next_nxt       = tick_next_r;
    press_begin_nxt     = press_begin_r;
    release_time_nxt    = release_time_r;
    far_press_begin_nxt = far_press_begin_r;
    activity_time_nxt   = activity_time_r;
    key_down_nxt        = key_down_r;
    far_key_down_nxt    = far_key_down_r;
    switching_nxt       = switching_r;
    mode_nxt            = mode_r;
    buzzer_nxt          = buzzer_r;
    link_nxt            = link_r;
    sym_count_nxt       = sym_count_r;
    sym_pattern_nxt     = sym_pattern_r;
    finish              = 1'b0;
    push                = 1'b0;
    push_dash           = 1'b0;
    res                 = '0;

    case (item_i.op)
      OP_TICK: begin
        tick_now_nxt  = tick_next_r;
        tick_next_nxt = tick_next_r + TIME_BITS'(1);
        if (item_i.local_key) begin
          if (!key_down_r) begin
            press_begin_nxt = tick_next_r;
            key_down_nxt    = 1'b1;
            if (link_r != LINK_RX) begin
              buzzer_nxt        = 1'b1;
              res.send_down     = 1'b1;
              link_nxt          = LINK_TX;
              activity_time_nxt = tick_next_r;
            end
          end else if (!switching_r && press_dur >= hold_lim) begin
            switching_nxt    = 1'b1;
            mode_nxt         = !mode_r;
            res.mode_changed = 1'b1;
          end
        end else if (switching_r) begin
          // release that ends a mode toggle hold
          switching_nxt = 1'b0;
          key_down_nxt  = 1'b0;
        end else if (key_down_r) begin
          key_down_nxt     = 1'b0;
          release_time_nxt = tick_next_r;
          buzzer_nxt       = 1'b0;
          if (link_r != LINK_RX) begin
            res.send_up       = 1'b1;
            activity_time_nxt = tick_next_r;
            if (press_dur < hold_lim) begin
              if (press_dur > dash_lim) begin
                finish   = 1'b1;
                link_nxt = LINK_TX;
              end else begin
                push      = 1'b1;
                push_dash = press_dur >= dot_lim;
                link_nxt  = LINK_TX;
              end
            end
          end
        end else begin
          if (sym_count_r != '0 && gap_dur >= gap_lim) begin
            finish = 1'b1;
          end
          if (link_r != LINK_FREE && idle_dur >= idle_lim) begin
            link_nxt   = LINK_FREE;
            buzzer_nxt = 1'b0;
          end
        end
      end
      OP_REMOTE_DOWN: begin
        if (!far_key_down_r) begin
          far_key_down_nxt    = 1'b1;
          far_press_begin_nxt = tick_now_r;
          buzzer_nxt          = 1'b1;
          link_nxt            = LINK_RX;
          activity_time_nxt   = tick_now_r;
        end
      end
      OP_REMOTE_UP: begin
        if (far_key_down_r) begin
          far_key_down_nxt    = 1'b0;
          far_press_begin_nxt = '0;
          buzzer_nxt          = 1'b0;
          activity_time_nxt   = tick_now_r;
          if (far_dur <= dash_lim) begin
            res.emit_valid   = 1'b1;
            res.emit_channel = CHAN_RX;
            res.emit_char    = (far_dur < dot_lim) ? CH_DOT : CH_DASH;
            link_nxt         = LINK_RX;
            release_time_nxt = tick_now_r;
          end
        end
      end
      default: ;
    endcase

    // letter end: decode in didactic mode and clear the symbol store
    // an empty store has no letter to end
    if (finish && sym_count_r != '0) begin
      if (!mode_r) begin
        if (letter != '0) begin
          res.emit_valid   = 1'b1;
          res.emit_channel = CHAN_TX;
          res.emit_char    = letter;
        end else begin
          res.unknown_letter = 1'b1;
        end
      end
      sym_count_nxt   = '0;
      sym_pattern_nxt = '0;
    end

    // new local symbol
    if (push) begin
      if (sym_count_r < SYM_CNT_W'(MAX_SYMBOLS)) begin
        if (sym_count_r < SYM_CNT_W'(4) && push_dash) begin
          sym_pattern_nxt[sym_count_r[1:0]] = 1'b1;
        end
        sym_count_nxt = sym_count_r + SYM_CNT_W'(1);
      end
      if (mode_r) begin
        res.emit_valid   = 1'b1;
        res.emit_channel = CHAN_TX;
        res.emit_char    = push_dash ? CH_DASH : CH_DOT;
      end
    end

    res.buzzer     = buzzer_nxt;
    res.link_state = link_nxt;
    res.mode       = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_now_r        <= '0;
      tick_next_r       <= TIME_BITS'(1);
      press_begin_r     <= '0;
      release_time_r    <= '0;
      far_press_begin_r <= '0;
      activity_time_r   <= '0;
      key_down_r        <= 1'b0;
      far_key_down_r    <= 1'b0;
      switching_r       <= 1'b0;
      mode_r            <= 1'b0;
      buzzer_r          <= 1'b0;
      link_r            <= LINK_FREE;
      sym_count_r       <= '0;
      sym_pattern_r     <= '0;
    end else if (fire_i) begin
      tick_now_r        <= tick_now_nxt;
      tick_next_r       <= tick_next_nxt;
      press_begin_r     <= press_begin_nxt;
      release_time_r    <= release_time_nxt;
      far_press_begin_r <= far_press_begin_nxt;
      activity_time_r   <= activity_time_nxt;
      key_down_r        <= key_down_nxt;
      far_key_down_r    <= far_key_down_nxt;
      switching_r       <= switching_nxt;
      mode_r            <= mode_nxt;
      buzzer_r          <= buzzer_nxt;
      link_r            <= link_nxt;
      sym_count_r       <= sym_count_nxt;
      sym_pattern_r     <= sym_pattern_nxt;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

FILE: rtl/core/mkd_out_stage.sv
// result register driving the output channel
`default_nettype none

module mkd_out_stage
  import mkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  result_t    result_i,
  output logic       can_load_o,
  mkd_out_if.source  out_chan
);

  logic    valid_r;
  result_t result_r;

  assign can_load_o = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.buzzer         = result_r.buzzer;
  assign out_chan.link_state     = result_r.link_state;
  assign out_chan.mode           = result_r.mode;
  assign out_chan.mode_changed   = result_r.mode_changed;
  assign out_chan.send_down      = result_r.send_down;
  assign out_chan.send_up        = result_r.send_up;
  assign out_chan.emit_valid     = result_r.emit_valid;
  assign out_chan.emit_channel   = result_r.emit_channel;
  assign out_chan.emit_char      = result_r.emit_char;
  assign out_chan.unknown_letter = result_r.unknown_letter;

endmodule

`default_nettype wire

FILE: rtl/core/morse_key_decoder_top.sv
// top level of the morse key timer and letter decoder
//
// in_chan carries one transaction per local key tick (op tick with the key
// level) or per remote key down/up event. out_chan returns exactly one result
// transaction for each input transaction, in order: buzzer, link state, mode,
// the send down/up strobes, an optional emitted character and the unknown
// letter flag.
// cfg_we/cfg_index/cfg_data write the five 16-bit timing thresholds; an index
// beyond the last register is dropped. write only while the block is idle.
// a transaction accepted into the input register is decoded once the result
// register is free and loaded into it; the result register drives out_chan.
// throughput: one transaction per cycle unless the receiver stalls; the whole
// step is one pass of compares and a small letter table between the input and
// result registers. when the receiver stalls, the result register holds its
// transaction and the input register takes one more; then in_chan.ready drops.
// reset (rst_n low, synchronous) clears all timers, the link to free, the
// mode to didactic, the symbol store, both stage valids, and loads the
// default thresholds.
`default_nettype none

module morse_key_decoder_top
  import mkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mkd_in_if.sink               in_chan,
  mkd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  reg_val_t             cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    fire;
  result_t result;

  // a decode step runs when an item waits and the result slot is free
  assign fire = item_valid && can_load;

  mkd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  mkd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mkd_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  mkd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (fire),
    .result_i   (result),
    .can_load_o (can_load),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mkd_checker.sv
// port level checks on the decoder result channel, bound to the top level
`default_nettype none

module mkd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire       buzzer,
  input wire [1:0] link_state,
  input wire       mode,
  input wire       mode_changed,
  input wire       send_down,
  input wire       send_up,
  input wire       emit_valid,
  input wire       emit_channel,
  input wire [6:0] emit_char,
  input wire       unknown_letter
);

  // stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({buzzer, link_state, mode, mode_changed, send_down, send_up,
               emit_valid, emit_channel, emit_char, unknown_letter}))
    else $error("result changed while stalled");

  // no result right after a reset cycle
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // strobes exclusive and link code legal
  a_link_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (link_state != 2'd3) && !(send_down && send_up))
    else $error("bad link state or strobes");

  // a mode toggle happens mid hold, so nothing else is reported with it
  a_toggle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_changed |->
      !emit_valid && !send_up && !send_down && !unknown_letter)
    else $error("mode toggle with other events");

  // idle character fields read zero
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !emit_valid |-> (emit_char == 7'd0) && !emit_channel)
    else $error("character fields set without emit");

endmodule

bind morse_key_decoder_top mkd_checker u_mkd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .buzzer         (out_chan.buzzer),
  .link_state     (out_chan.link_state),
  .mode           (out_chan.mode),
  .mode_changed   (out_chan.mode_changed),
  .send_down      (out_chan.send_down),
  .send_up        (out_chan.send_up),
  .emit_valid     (out_chan.emit_valid),
  .emit_channel   (out_chan.emit_channel),
  .emit_char      (out_chan.emit_char),
  .unknown_letter (out_chan.unknown_letter)
);

`default_nettype wire
